// ===== hw/rtl/h264ps_pkg.sv =====
// Package: shared types, codes and constant tables of the parameter set parser.
`timescale 1ns / 1ps
`default_nettype none
package h264ps_pkg;

    // Default table depths
    localparam int SEQ_SLOTS_DEF = 32;
    localparam int PIC_SLOTS_DEF = 256;

    // Byte queue between front and back
    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    // NAL unit types
    localparam logic [4:0] NAL_SLICE = 5'd1;
    localparam logic [4:0] NAL_IDR   = 5'd5;
    localparam logic [4:0] NAL_SPS   = 5'd7;
    localparam logic [4:0] NAL_PPS   = 5'd8;

    // Result status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_IGNORED   = 3'd1;
    localparam logic [2:0] STAT_LEVEL     = 3'd2;
    localparam logic [2:0] STAT_POC       = 3'd3;
    localparam logic [2:0] STAT_SLICETYPE = 3'd4;
    localparam logic [2:0] STAT_NOBUF     = 3'd5;
    localparam logic [2:0] STAT_IDRANGE   = 3'd6;
    localparam logic [2:0] STAT_TRUNC     = 3'd7;

    // Unit kinds
    localparam logic [1:0] KIND_SPS   = 2'd0;
    localparam logic [1:0] KIND_PPS   = 2'd1;
    localparam logic [1:0] KIND_SLICE = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // Frame types
    localparam logic [1:0] FT_I = 2'd0;
    localparam logic [1:0] FT_P = 2'd1;
    localparam logic [1:0] FT_B = 2'd2;

    // Chroma format classes
    localparam logic [1:0] CF_MONO = 2'd0;
    localparam logic [1:0] CF_420  = 2'd1;
    localparam logic [1:0] CF_422  = 2'd2;
    localparam logic [1:0] CF_444  = 2'd3;

    typedef enum logic [1:0] {RD_FIX, RD_UE, RD_SE} t_rdmode;

    typedef enum logic [5:0] {
        ST_DONE,
        S_PROFILE, S_CONSTR, S_LEVEL, S_SPSID, S_CHROMA, S_SEPPLANE, S_DEPTHL,
        S_DEPTHC, S_BYPASS, S_MATRIX, S_LISTFLAG, S_DELTA, S_FRAMENUM, S_POCTYPE,
        S_POCLSB, S_POCZERO, S_OFFNR, S_OFFTB, S_CYCLE, S_OFFREF, S_REFS, S_GAPS,
        S_WMBS, S_HMBS, S_FMO, S_MBAFF, S_D8, S_CROPF, S_CL, S_CR, S_CT, S_CB,
        S_VUI, S_ARP, S_ARIDC, S_SARW, S_SARH,
        P_PPSID, P_SPSID,
        L_FIRSTMB, L_TYPE, L_PPSID,
        S_FIN, L_RD1, L_RD2
    } t_step;

    // One queued byte beat
    typedef struct packed {
        logic [7:0] data;
        logic       hdr;
        logic       skip;
        logic       last;
    } t_beat;

    // Bit reader state
    typedef struct packed {
        t_step       step;
        t_rdmode     mode;
        logic        phase;
        logic [31:0] gval;
        logic [5:0]  gzeros;
    } t_rd;

    // Per-unit parse results
    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  kind;
        logic [7:0]  pid;
        logic        pid_ge;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] anum;
        logic [15:0] aden;
        logic [24:0] buffer;
        logic [1:0]  ftype;
        logic        hiprof;
        logic [1:0]  ccls;
        logic        sepplane;
        logic        fmo;
        logic [31:0] wmbs;
        logic [31:0] hmbs;
        logic [32:0] crop_lr;
        logic [32:0] crop_tb;
    } t_unit;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  kind;
        logic [7:0]  pid;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] anum;
        logic [15:0] aden;
        logic [24:0] buffer;
        logic [1:0]  ftype;
    } t_result;

    // Level ids in table order
    function automatic logic [7:0] level_id(input logic [3:0] k);
        logic [7:0] r;
        case (k)
            4'd0:    r = 8'd10;
            4'd1:    r = 8'd11;
            4'd2:    r = 8'd12;
            4'd3:    r = 8'd13;
            4'd4:    r = 8'd20;
            4'd5:    r = 8'd21;
            4'd6:    r = 8'd22;
            4'd7:    r = 8'd30;
            4'd8:    r = 8'd31;
            4'd9:    r = 8'd32;
            4'd10:   r = 8'd40;
            4'd11:   r = 8'd41;
            4'd12:   r = 8'd42;
            4'd13:   r = 8'd50;
            4'd14:   r = 8'd51;
            default: r = 8'd255;
        endcase
        return r;
    endfunction

    // Buffer size in bytes per level entry (kbit * 125)
    function automatic logic [24:0] level_bytes(input logic [3:0] k);
        logic [24:0] r;
        case (k)
            4'd0:    r = 25'd21875;
            4'd1:    r = 25'd62500;
            4'd2:    r = 25'd125000;
            4'd3:    r = 25'd250000;
            4'd4:    r = 25'd250000;
            4'd5:    r = 25'd500000;
            4'd6:    r = 25'd500000;
            4'd7:    r = 25'd1250000;
            4'd8:    r = 25'd1750000;
            4'd9:    r = 25'd2500000;
            4'd10:   r = 25'd3125000;
            4'd11:   r = 25'd7812500;
            4'd12:   r = 25'd7812500;
            4'd13:   r = 25'd16875000;
            4'd14:   r = 25'd30000000;
            default: r = 25'd0;
        endcase
        return r;
    endfunction

    // First entry whose id is not below the level; 15 when none
    function automatic logic [3:0] level_index(input logic [31:0] lvl);
        logic [3:0] r;
        r = 4'd15;
        for (int k = 14; k >= 0; k--) begin
            if ({24'd0, level_id(4'(k))} >= lvl) r = 4'(k);
        end
        return r;
    endfunction

    function automatic logic [15:0] sar_num(input logic [4:0] k);
        logic [15:0] r;
        case (k)
            5'd1:    r = 16'd1;
            5'd2:    r = 16'd12;
            5'd3:    r = 16'd10;
            5'd4:    r = 16'd16;
            5'd5:    r = 16'd40;
            5'd6:    r = 16'd24;
            5'd7:    r = 16'd20;
            5'd8:    r = 16'd32;
            5'd9:    r = 16'd80;
            5'd10:   r = 16'd18;
            5'd11:   r = 16'd15;
            5'd12:   r = 16'd64;
            5'd13:   r = 16'd160;
            5'd14:   r = 16'd4;
            5'd15:   r = 16'd3;
            5'd16:   r = 16'd2;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] sar_den(input logic [4:0] k);
        logic [15:0] r;
        case (k)
            5'd0, 5'd1, 5'd16:                   r = 16'd1;
            5'd5, 5'd9, 5'd12:                   r = 16'd33;
            5'd13:                               r = 16'd99;
            5'd14:                               r = 16'd3;
            5'd15:                               r = 16'd2;
            default:                             r = 16'd11;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/h264ps_if.sv =====
// Interfaces: byte input channel and result output channel.
`timescale 1ns / 1ps
`default_nettype none
interface h264ps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface h264ps_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  unit_kind;
    logic [7:0]  param_id;
    logic [15:0] pixel_width;
    logic [15:0] pixel_height;
    logic [15:0] aspect_num;
    logic [15:0] aspect_den;
    logic [24:0] buffer_bytes;
    logic [1:0]  frame_type;
    modport source (output valid, status, unit_kind, param_id, pixel_width, pixel_height,
                    aspect_num, aspect_den, buffer_bytes, frame_type, input ready);
    modport sink (input valid, status, unit_kind, param_id, pixel_width, pixel_height,
                  aspect_num, aspect_den, buffer_bytes, frame_type, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/h264_parameter_set_parser.sv =====
// The bit parser walks a payload byte one bit per cycle and then hands it off; a header beat
// or an escape byte skips the walk. After the last bit of a unit is parsed, a sequence set
// runs the size step and a slice the pps map and buffer table reads before its result.
// The walk stalls in those steps and on a full result register; the four-beat queue still fills.
// Reset: synchronous active low; both id tables read as zero after reset via per-entry
// valid bits, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module h264_parameter_set_parser #(
    parameter int SEQ_SLOTS = h264ps_pkg::SEQ_SLOTS_DEF,
    parameter int PIC_SLOTS = h264ps_pkg::PIC_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    h264ps_in_if.sink     i_in,
    h264ps_out_if.source  o_out
);
    import h264ps_pkg::*;

    t_beat push_beat, pop_beat;
    logic  push, pop, full, empty;

    h264ps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_beat  (push_beat)
    );

    h264ps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat  (push_beat),
        .o_full  (full),
        .i_pop   (pop),
        .o_beat  (pop_beat),
        .o_empty (empty)
    );

    h264ps_back #(
        .SEQ_SLOTS (SEQ_SLOTS),
        .PIC_SLOTS (PIC_SLOTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (pop_beat),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/h264ps_front.sv =====
// Front end: accepts byte beats, tracks unit framing and marks escape bytes.
`timescale 1ns / 1ps
`default_nettype none
module h264ps_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    h264ps_in_if.sink            i_in,
    input  logic                 i_full,
    output logic                 o_push,
    output h264ps_pkg::t_beat    o_beat
);
    import h264ps_pkg::*;

    logic       r_active;
    logic [1:0] r_zero_run;
    logic       acc;

    assign i_in.ready = !i_full;
    assign acc = i_in.valid && i_in.ready;

    // Classify the beat
    always_comb begin
        o_beat.data = i_in.data_byte;
        o_beat.hdr  = i_in.first_byte;
        o_beat.last = i_in.last_byte;
        o_beat.skip = !i_in.first_byte && (r_zero_run == 2'd2) && (i_in.data_byte == 8'h03);
        o_push      = acc && (i_in.first_byte || r_active);
    end

    // Unit framing and zero run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_zero_run <= 2'd0;
        end else if (acc) begin
            if (i_in.first_byte) begin
                r_active   <= !i_in.last_byte;
                r_zero_run <= 2'd0;
            end else if (r_active) begin
                if (o_beat.skip || i_in.data_byte != 8'h00) r_zero_run <= 2'd0;
                else if (r_zero_run != 2'd2) r_zero_run <= r_zero_run + 2'd1;
                if (i_in.last_byte) r_active <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/h264ps_fifo.sv =====
// Short beat queue between the front end and the bit parser.
`timescale 1ns / 1ps
`default_nettype none
module h264ps_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  h264ps_pkg::t_beat i_beat,
    output logic              o_full,
    input  logic              i_pop,
    output h264ps_pkg::t_beat o_beat,
    output logic              o_empty
);
    import h264ps_pkg::*;

    t_beat              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_beat  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_beat;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/h264ps_back.sv =====
// Back end: bit-serial exp-Golomb parser, id tables and result register.
`timescale 1ns / 1ps
`default_nettype none
module h264ps_back #(
    parameter int SEQ_SLOTS = h264ps_pkg::SEQ_SLOTS_DEF,
    parameter int PIC_SLOTS = h264ps_pkg::PIC_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  h264ps_pkg::t_beat i_beat,
    input  logic              i_empty,
    output logic              o_pop,
    h264ps_out_if.source      o_out
);
    import h264ps_pkg::*;

    localparam int SEQ_AW = (SEQ_SLOTS > 1) ? $clog2(SEQ_SLOTS) : 1;
    localparam int PIC_AW = (PIC_SLOTS > 1) ? $clog2(PIC_SLOTS) : 1;

    t_rd         r_rd, n_rd;
    t_unit       r_u, n_u;
    logic [15:0] r_held, n_held;
    logic [15:0] r_sl, n_sl;
    logic [10:0] r_lc, n_lc;
    logic [31:0] r_sa, n_sa;
    logic        r_have, n_have;
    logic [7:0]  r_byte, n_byte;
    logic        r_last, n_last;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_ov, n_ov;
    t_result     r_res, n_res;

    // Tables
    logic [24:0]          seq_mem [SEQ_SLOTS];
    logic [SEQ_SLOTS-1:0] r_seq_vld;
    logic [4:0]           pic_mem [PIC_SLOTS];
    logic [PIC_SLOTS-1:0] r_pic_vld;
    logic                 seq_we, seq_re, pic_we, pic_re;
    logic [SEQ_AW-1:0]    seq_wa, seq_ra;
    logic [PIC_AW-1:0]    pic_wa, pic_ra;
    logic [24:0]          seq_wd, r_seq_q;
    logic [4:0]           pic_wd, r_pic_q;
    logic                 r_seq_qv, r_pic_qv;

    function automatic t_rd go_rd(input t_step s, input t_rdmode m, input logic [5:0] n);
        t_rd r;
        r.step   = s;
        r.mode   = m;
        r.phase  = 1'b0;
        r.gval   = '0;
        r.gzeros = (m == RD_FIX) ? n : 6'd0;
        return r;
    endfunction

    function automatic logic [15:0] clamp16(input logic [37:0] x, input logic [37:0] sub);
        logic [37:0] d;
        d = (x > sub) ? x - sub : 38'd0;
        return (d > 38'd65535) ? 16'hFFFF : d[15:0];
    endfunction

    // Bit reader
    logic        bit_in;
    logic        fb_done;
    logic [31:0] fb_ue, fb_v;
    t_rd         fb_rd;

    assign bit_in = r_byte[3'd7 - r_cnt[2:0]];

    always_comb begin
        fb_rd   = r_rd;
        fb_done = 1'b0;
        fb_ue   = '0;
        if (r_rd.mode == RD_FIX) begin
            fb_rd.gval   = {r_rd.gval[30:0], bit_in};
            fb_rd.gzeros = r_rd.gzeros - 6'd1;
            fb_done      = (fb_rd.gzeros == 6'd0);
            fb_ue        = fb_rd.gval;
        end else if (!r_rd.phase) begin
            if (!bit_in) begin
                fb_rd.gzeros = r_rd.gzeros + 6'd1;
                if (fb_rd.gzeros >= 6'd32) begin
                    fb_done = 1'b1;
                    fb_ue   = 32'hFFFF_FFFF;
                end
            end else if (r_rd.gzeros == 6'd0) begin
                fb_done = 1'b1;
            end else begin
                fb_rd.gval  = 32'd1;
                fb_rd.phase = 1'b1;
            end
        end else begin
            fb_rd.gval   = {r_rd.gval[30:0], bit_in};
            fb_rd.gzeros = r_rd.gzeros - 6'd1;
            fb_done      = (fb_rd.gzeros == 6'd0);
            fb_ue        = fb_rd.gval - 32'd1;
        end
        // Signed mapping
        if (r_rd.mode == RD_SE) fb_v = fb_ue[0] ? {1'b0, fb_ue[31:1]} + 32'd1
                                                : 32'd0 - {1'b0, fb_ue[31:1]};
        else                    fb_v = fb_ue;
    end

    // Scaling list advance
    logic [4:0] nl_i;
    logic       nl_end;
    t_rd        nl_rd;
    logic [10:0] nl_lc;

    always_comb begin
        nl_i   = {1'b0, r_lc[10:7]} + 5'd1;
        nl_end = nl_i >= ((r_u.ccls == CF_444) ? 5'd12 : 5'd8);
        nl_rd  = nl_end ? go_rd(S_FRAMENUM, RD_UE, 6'd0) : go_rd(S_LISTFLAG, RD_FIX, 6'd1);
        nl_lc  = {nl_i[3:0], 7'd0};
    end

    // Sequence set size computation
    logic [1:0]  fin_cat;
    logic [1:0]  fin_cysh;
    logic [32:0] fin_w1, fin_h1;
    logic [37:0] fin_wx, fin_wsub, fin_hx, fin_hsub;

    always_comb begin
        fin_cat  = r_u.sepplane ? CF_MONO : r_u.ccls;
        fin_w1   = {1'b0, r_u.wmbs} + 33'd1;
        fin_h1   = {1'b0, r_u.hmbs} + 33'd1;
        fin_wx   = {1'b0, fin_w1, 4'd0};
        fin_hx   = r_u.fmo ? {1'b0, fin_h1, 4'd0} : {fin_h1, 5'd0};
        fin_wsub = (fin_cat == CF_420 || fin_cat == CF_422) ? {4'd0, r_u.crop_lr, 1'b0}
                                                            : {5'd0, r_u.crop_lr};
        fin_cysh = {1'b0, !r_u.fmo} + {1'b0, fin_cat == CF_420};
        fin_hsub = {5'd0, r_u.crop_tb} << fin_cysh;
    end

    // Sequencing
    logic       is_comp, do_bit, byte_end, out_free, release_b, emit, take;
    logic [3:0] lvl_k;
    logic [7:0] dl_last, dl_next;
    logic [7:0] dl_j;
    logic [31:0] st_t;
    logic [4:0]  rd_k;
    logic [24:0] rd_buf;
    logic [2:0]  em_st;
    logic        em_ok;

    assign is_comp   = (r_rd.step == S_FIN) || (r_rd.step == L_RD1) || (r_rd.step == L_RD2);
    assign do_bit    = r_have && !is_comp && !r_cnt[3] && (r_rd.step != ST_DONE);
    assign byte_end  = r_have && !is_comp && (r_cnt[3] || r_rd.step == ST_DONE);
    assign out_free  = !r_ov || o_out.ready;
    assign release_b = byte_end && (!r_last || out_free);
    assign emit      = byte_end && r_last && out_free;
    assign take      = (!r_have || release_b) && !i_empty;
    assign o_pop     = take;
    assign lvl_k     = level_index(r_sa);

    always_comb begin
        n_rd   = r_rd;
        n_u    = r_u;
        n_held = r_held;
        n_sl   = r_sl;
        n_lc   = r_lc;
        n_sa   = r_sa;
        n_have = r_have;
        n_byte = r_byte;
        n_last = r_last;
        n_cnt  = r_cnt;
        n_ov   = r_ov && !o_out.ready;
        n_res  = r_res;
        seq_we = 1'b0;
        seq_wa = '0;
        seq_wd = '0;
        seq_re = 1'b0;
        seq_ra = '0;
        pic_we = 1'b0;
        pic_wa = '0;
        pic_wd = '0;
        pic_re = 1'b0;
        pic_ra = '0;
        dl_last = r_sl[15:8] + fb_v[7:0];
        dl_next = dl_last;
        dl_j    = {1'b0, r_lc[6:0]} + 8'd1;
        st_t    = (fb_v > 32'd4) ? fb_v - 32'd5 : fb_v;
        rd_k    = r_pic_qv ? r_pic_q : 5'd0;
        rd_buf  = r_seq_qv ? r_seq_q : 25'd0;

        // One bit through the syntax walk
        if (do_bit) begin
            n_cnt = r_cnt + 4'd1;
            n_rd  = fb_rd;
            if (fb_done) begin
                case (r_rd.step)
                    S_PROFILE: begin
                        n_u.hiprof = fb_v >= 32'd100;
                        n_rd = go_rd(S_CONSTR, RD_FIX, 6'd8);
                    end
                    S_CONSTR: n_rd = go_rd(S_LEVEL, RD_FIX, 6'd8);
                    S_LEVEL: begin
                        n_sa = fb_v;
                        n_rd = go_rd(S_SPSID, RD_UE, 6'd0);
                    end
                    S_SPSID: begin
                        n_u.pid = fb_v[7:0];
                        if (lvl_k == 4'd15) begin
                            n_u.status = STAT_LEVEL;
                            n_rd.step  = ST_DONE;
                        end else if (fb_v >= 32'(SEQ_SLOTS)) begin
                            n_u.status = STAT_IDRANGE;
                            n_rd.step  = ST_DONE;
                        end else begin
                            n_u.buffer = level_bytes(lvl_k);
                            seq_we = 1'b1;
                            seq_wa = fb_v[SEQ_AW-1:0];
                            seq_wd = level_bytes(lvl_k);
                            n_rd = r_u.hiprof ? go_rd(S_CHROMA, RD_UE, 6'd0)
                                              : go_rd(S_FRAMENUM, RD_UE, 6'd0);
                        end
                    end
                    S_CHROMA: begin
                        if (fb_v == 32'd0)      n_u.ccls = CF_MONO;
                        else if (fb_v == 32'd2) n_u.ccls = CF_422;
                        else if (fb_v == 32'd3) n_u.ccls = CF_444;
                        else                    n_u.ccls = CF_420;
                        n_rd = (fb_v == 32'd3) ? go_rd(S_SEPPLANE, RD_FIX, 6'd1)
                                               : go_rd(S_DEPTHL, RD_UE, 6'd0);
                    end
                    S_SEPPLANE: begin
                        n_u.sepplane = fb_v[0];
                        n_rd = go_rd(S_DEPTHL, RD_UE, 6'd0);
                    end
                    S_DEPTHL: n_rd = go_rd(S_DEPTHC, RD_UE, 6'd0);
                    S_DEPTHC: n_rd = go_rd(S_BYPASS, RD_FIX, 6'd1);
                    S_BYPASS: n_rd = go_rd(S_MATRIX, RD_FIX, 6'd1);
                    S_MATRIX: begin
                        if (fb_v[0]) begin
                            n_lc = '0;
                            n_rd = go_rd(S_LISTFLAG, RD_FIX, 6'd1);
                        end else begin
                            n_rd = go_rd(S_FRAMENUM, RD_UE, 6'd0);
                        end
                    end
                    S_LISTFLAG: begin
                        if (fb_v[0]) begin
                            n_sl = 16'h0808;
                            n_lc = {r_lc[10:7], 7'd0};
                            n_rd = go_rd(S_DELTA, RD_SE, 6'd0);
                        end else begin
                            n_rd = nl_rd;
                            if (!nl_end) n_lc = nl_lc;
                        end
                    end
                    S_DELTA: begin
                        // Next scale; a zero keeps the previous one as last
                        dl_next = r_sl[15:8] + fb_v[7:0];
                        dl_last = (dl_next != 8'd0) ? dl_next : r_sl[15:8];
                        n_sl = {dl_last, dl_next};
                        n_lc = {r_lc[10:7], dl_j[6:0]};
                        if (dl_next == 8'd0 ||
                            dl_j >= ((r_lc[10:7] < 4'd6) ? 8'd16 : 8'd64)) begin
                            n_rd = nl_rd;
                            if (!nl_end) n_lc = nl_lc;
                        end else begin
                            n_rd = go_rd(S_DELTA, RD_SE, 6'd0);
                        end
                    end
                    S_FRAMENUM: n_rd = go_rd(S_POCTYPE, RD_UE, 6'd0);
                    S_POCTYPE: begin
                        if (fb_v == 32'd0)      n_rd = go_rd(S_POCLSB, RD_UE, 6'd0);
                        else if (fb_v == 32'd1) n_rd = go_rd(S_POCZERO, RD_FIX, 6'd1);
                        else if (fb_v == 32'd2) n_rd = go_rd(S_REFS, RD_UE, 6'd0);
                        else begin
                            n_u.status = STAT_POC;
                            n_rd.step  = ST_DONE;
                        end
                    end
                    S_POCLSB:  n_rd = go_rd(S_REFS, RD_UE, 6'd0);
                    S_POCZERO: n_rd = go_rd(S_OFFNR, RD_SE, 6'd0);
                    S_OFFNR:   n_rd = go_rd(S_OFFTB, RD_SE, 6'd0);
                    S_OFFTB:   n_rd = go_rd(S_CYCLE, RD_UE, 6'd0);
                    S_CYCLE: begin
                        n_sa = fb_v;
                        n_rd = (fb_v == 32'd0) ? go_rd(S_REFS, RD_UE, 6'd0)
                                               : go_rd(S_OFFREF, RD_SE, 6'd0);
                    end
                    S_OFFREF: begin
                        n_sa = r_sa - 32'd1;
                        n_rd = (n_sa == 32'd0) ? go_rd(S_REFS, RD_UE, 6'd0)
                                               : go_rd(S_OFFREF, RD_SE, 6'd0);
                    end
                    S_REFS: n_rd = go_rd(S_GAPS, RD_FIX, 6'd1);
                    S_GAPS: n_rd = go_rd(S_WMBS, RD_UE, 6'd0);
                    S_WMBS: begin
                        n_u.wmbs = fb_v;
                        n_rd = go_rd(S_HMBS, RD_UE, 6'd0);
                    end
                    S_HMBS: begin
                        n_u.hmbs = fb_v;
                        n_rd = go_rd(S_FMO, RD_FIX, 6'd1);
                    end
                    S_FMO: begin
                        n_u.fmo = fb_v[0];
                        n_rd = fb_v[0] ? go_rd(S_D8, RD_FIX, 6'd1)
                                       : go_rd(S_MBAFF, RD_FIX, 6'd1);
                    end
                    S_MBAFF: n_rd = go_rd(S_D8, RD_FIX, 6'd1);
                    S_D8:    n_rd = go_rd(S_CROPF, RD_FIX, 6'd1);
                    S_CROPF: n_rd = fb_v[0] ? go_rd(S_CL, RD_UE, 6'd0)
                                            : go_rd(S_VUI, RD_FIX, 6'd1);
                    S_CL: begin
                        n_u.crop_lr = r_u.crop_lr + {1'b0, fb_v};
                        n_rd = go_rd(S_CR, RD_UE, 6'd0);
                    end
                    S_CR: begin
                        n_u.crop_lr = r_u.crop_lr + {1'b0, fb_v};
                        n_rd = go_rd(S_CT, RD_UE, 6'd0);
                    end
                    S_CT: begin
                        n_u.crop_tb = r_u.crop_tb + {1'b0, fb_v};
                        n_rd = go_rd(S_CB, RD_UE, 6'd0);
                    end
                    S_CB: begin
                        n_u.crop_tb = r_u.crop_tb + {1'b0, fb_v};
                        n_rd = go_rd(S_VUI, RD_FIX, 6'd1);
                    end
                    S_VUI: n_rd = fb_v[0] ? go_rd(S_ARP, RD_FIX, 6'd1)
                                          : go_rd(S_FIN, RD_FIX, 6'd1);
                    S_ARP: n_rd = fb_v[0] ? go_rd(S_ARIDC, RD_FIX, 6'd8)
                                          : go_rd(S_FIN, RD_FIX, 6'd1);
                    S_ARIDC: begin
                        if (fb_v == 32'd255) begin
                            n_rd = go_rd(S_SARW, RD_FIX, 6'd16);
                        end else begin
                            if (fb_v < 32'd17) begin
                                n_u.anum = sar_num(fb_v[4:0]);
                                n_held   = sar_den(fb_v[4:0]);
                            end
                            n_rd = go_rd(S_FIN, RD_FIX, 6'd1);
                        end
                    end
                    S_SARW: begin
                        n_u.anum = fb_v[15:0];
                        n_rd = go_rd(S_SARH, RD_FIX, 6'd16);
                    end
                    S_SARH: begin
                        n_held = fb_v[15:0];
                        n_rd = go_rd(S_FIN, RD_FIX, 6'd1);
                    end
                    P_PPSID: begin
                        n_u.pid    = fb_v[7:0];
                        n_u.pid_ge = fb_v >= 32'(PIC_SLOTS);
                        n_rd = go_rd(P_SPSID, RD_UE, 6'd0);
                    end
                    P_SPSID: begin
                        n_rd.step = ST_DONE;
                        if (r_u.pid_ge || fb_v >= 32'(SEQ_SLOTS)) begin
                            n_u.status = STAT_IDRANGE;
                        end else begin
                            pic_we = 1'b1;
                            pic_wa = r_u.pid[PIC_AW-1:0];
                            pic_wd = fb_v[4:0];
                            n_u.status = STAT_OK;
                        end
                    end
                    L_FIRSTMB: n_rd = go_rd(L_TYPE, RD_UE, 6'd0);
                    L_TYPE: begin
                        n_rd = go_rd(L_PPSID, RD_UE, 6'd0);
                        if (st_t == 32'd0)      n_u.ftype = FT_P;
                        else if (st_t == 32'd1) n_u.ftype = FT_B;
                        else if (st_t == 32'd2) n_u.ftype = FT_I;
                        else begin
                            n_u.status = STAT_SLICETYPE;
                            n_rd.step  = ST_DONE;
                        end
                    end
                    L_PPSID: begin
                        n_u.pid = fb_v[7:0];
                        if (fb_v >= 32'(PIC_SLOTS)) begin
                            n_u.status = STAT_IDRANGE;
                            n_rd.step  = ST_DONE;
                        end else begin
                            pic_re = 1'b1;
                            pic_ra = fb_v[PIC_AW-1:0];
                            n_rd.step = L_RD1;
                        end
                    end
                    default: begin
                        n_u.status = STAT_OK;
                        n_rd.step  = ST_DONE;
                    end
                endcase
            end
        end

        // Computation steps that stall the bit walk
        if (r_have && is_comp) begin
            case (r_rd.step)
                S_FIN: begin
                    n_u.width  = clamp16(fin_wx, fin_wsub);
                    n_u.height = clamp16(fin_hx, fin_hsub);
                    n_u.aden   = r_held;
                    n_u.status = STAT_OK;
                    n_rd.step  = ST_DONE;
                end
                L_RD1: begin
                    if ({1'b0, rd_k} >= 6'(SEQ_SLOTS)) begin
                        n_u.status = STAT_NOBUF;
                        n_rd.step  = ST_DONE;
                    end else begin
                        seq_re = 1'b1;
                        seq_ra = rd_k[SEQ_AW-1:0];
                        n_rd.step = L_RD2;
                    end
                end
                default: begin
                    n_rd.step = ST_DONE;
                    if (rd_buf == 25'd0) begin
                        n_u.status = STAT_NOBUF;
                    end else begin
                        n_u.buffer = rd_buf;
                        n_u.status = STAT_OK;
                    end
                end
            endcase
        end

        // Result beat
        em_st = (r_rd.step != ST_DONE) ? STAT_TRUNC : r_u.status;
        em_ok = (em_st == STAT_OK);
        if (emit) begin
            n_ov         = 1'b1;
            n_res.status = em_st;
            n_res.kind   = r_u.kind;
            n_res.pid    = r_u.pid;
            n_res.width  = em_ok ? r_u.width  : 16'd0;
            n_res.height = em_ok ? r_u.height : 16'd0;
            n_res.anum   = em_ok ? r_u.anum   : 16'd0;
            n_res.aden   = em_ok ? r_u.aden   : 16'd0;
            n_res.buffer = em_ok ? r_u.buffer : 25'd0;
            n_res.ftype  = em_ok ? r_u.ftype  : 2'd0;
        end

        // Next beat from the queue
        if (release_b) n_have = 1'b0;
        if (take) begin
            n_have = 1'b1;
            n_byte = i_beat.data;
            n_last = i_beat.last;
            n_cnt  = (i_beat.hdr || i_beat.skip) ? 4'd8 : 4'd0;
            if (i_beat.hdr) begin
                n_u      = '0;
                n_u.ccls = CF_420;
                n_sl     = 16'h0808;
                n_lc     = '0;
                n_sa     = '0;
                if (i_beat.data[4:0] == NAL_SPS) begin
                    n_u.kind = KIND_SPS;
                    n_rd = go_rd(S_PROFILE, RD_FIX, 6'd8);
                end else if (i_beat.data[4:0] == NAL_PPS) begin
                    n_u.kind = KIND_PPS;
                    n_rd = go_rd(P_PPSID, RD_UE, 6'd0);
                end else if (i_beat.data[4:0] inside {NAL_SLICE, NAL_IDR}) begin
                    n_u.kind = KIND_SLICE;
                    n_rd = go_rd(L_FIRSTMB, RD_UE, 6'd0);
                end else begin
                    n_u.kind   = KIND_OTHER;
                    n_u.status = STAT_IGNORED;
                    n_rd = go_rd(ST_DONE, RD_FIX, 6'd1);
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd      <= go_rd(ST_DONE, RD_FIX, 6'd1);
            r_held    <= 16'd1;
            r_have    <= 1'b0;
            r_cnt     <= 4'd0;
            r_ov      <= 1'b0;
            r_seq_vld <= '0;
            r_pic_vld <= '0;
        end else begin
            r_rd   <= n_rd;
            r_held <= n_held;
            r_have <= n_have;
            r_cnt  <= n_cnt;
            r_ov   <= n_ov;
            if (seq_we) r_seq_vld[seq_wa] <= 1'b1;
            if (pic_we) r_pic_vld[pic_wa] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_u    <= n_u;
        r_sl   <= n_sl;
        r_lc   <= n_lc;
        r_sa   <= n_sa;
        r_byte <= n_byte;
        r_last <= n_last;
        r_res  <= n_res;
        if (seq_re) r_seq_qv <= r_seq_vld[seq_ra];
        if (pic_re) r_pic_qv <= r_pic_vld[pic_ra];
    end

    // Table memories
    always_ff @(posedge i_clk) begin
        if (seq_we) seq_mem[seq_wa] <= seq_wd;
        if (seq_re) r_seq_q <= seq_mem[seq_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pic_we) pic_mem[pic_wa] <= pic_wd;
        if (pic_re) r_pic_q <= pic_mem[pic_ra];
    end

    assign o_out.valid        = r_ov;
    assign o_out.status       = r_res.status;
    assign o_out.unit_kind    = r_res.kind;
    assign o_out.param_id     = r_res.pid;
    assign o_out.pixel_width  = r_res.width;
    assign o_out.pixel_height = r_res.height;
    assign o_out.aspect_num   = r_res.anum;
    assign o_out.aspect_den   = r_res.aden;
    assign o_out.buffer_bytes = r_res.buffer;
    assign o_out.frame_type   = r_res.ftype;
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the H.264 parameter set parser: byte-level NAL units in, one result per unit out.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import h264ps_pkg::*;

    logic i_clk;
    logic i_rst_n;

    h264ps_in_if  in_ch();
    h264ps_out_if out_ch();

    h264_parameter_set_parser u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor state
    t_result     expected_q[$];
    int          fail_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;

    logic [24:0] pm_seq_buf[SEQ_SLOTS_DEF];
    logic [4:0]  pm_pic_map[PIC_SLOTS_DEF];
    logic [15:0] pm_held_den;
    int unsigned pm_zeros_seen;
    t_step       pm_step;
    t_rdmode     pm_mode;
    bit          pm_phase;
    logic [31:0] pm_gval;
    int unsigned pm_gzeros;
    logic [15:0] pm_scale;
    logic [15:0] pm_loops;
    logic [31:0] pm_accum;
    bit          pm_active;
    // current unit
    logic [2:0]  cu_status;
    logic [1:0]  cu_kind;
    logic [31:0] cu_pid, cu_width, cu_height, cu_anum, cu_aden, cu_buffer, cu_ftype;
    logic [31:0] cu_profile, cu_chroma, cu_sepplane, cu_fmo, cu_wmbs, cu_hmbs;
    logic [63:0] cu_crop_lr, cu_crop_tb;

    // Bit-string builder for unit payloads
    bit          bits_q[$];

    function automatic void put_bits(input logic [31:0] v, input int n);
        for (int b = n - 1; b >= 0; b--) bits_q.push_back(v[b]);
    endfunction

    function automatic void put_ue(input logic [31:0] v);
        logic [32:0] x;
        int n;
        x = {1'b0, v} + 33'd1;
        n = 0;
        for (int b = 32; b >= 0; b--) if (x[b] && n == 0) n = b + 1;
        for (int b = 0; b < n - 1; b++) bits_q.push_back(1'b0);
        for (int b = n - 1; b >= 0; b--) bits_q.push_back(x[b]);
    endfunction

    function automatic void put_se(input int v);
        if (v > 0) put_ue(2 * v - 1);
        else put_ue(-2 * v);
    endfunction

    // Local table copies
    function automatic logic [7:0] lvl_id(input int k);
        int ids[15] = '{10, 11, 12, 13, 20, 21, 22, 30, 31, 32, 40, 41, 42, 50, 51};
        return ids[k];
    endfunction

    function automatic logic [31:0] lvl_bytes(input int k);
        int kb[15] = '{175, 500, 1000, 2000, 2000, 4000, 4000, 10000, 14000,
                       20000, 25000, 62500, 62500, 135000, 240000};
        return kb[k] * 125;
    endfunction

    function automatic logic [15:0] aspect_n(input int k);
        int t[17] = '{0, 1, 12, 10, 16, 40, 24, 20, 32, 80, 18, 15, 64, 160, 4, 3, 2};
        return t[k];
    endfunction

    function automatic logic [15:0] aspect_d(input int k);
        int t[17] = '{1, 1, 11, 11, 11, 33, 11, 11, 11, 33, 11, 11, 33, 99, 3, 2, 1};
        return t[k];
    endfunction

    function automatic void pm_go(input t_step s, input t_rdmode m, input int n);
        pm_step  = s;
        pm_mode  = m;
        pm_phase = 0;
        pm_gval  = 0;
        pm_gzeros = (m == RD_FIX) ? n : 0;
    endfunction

    function automatic void pm_end(input logic [2:0] st);
        cu_status = st;
        pm_step   = ST_DONE;
    endfunction

    function automatic void pm_reset();
        foreach (pm_seq_buf[k]) pm_seq_buf[k] = '0;
        foreach (pm_pic_map[k]) pm_pic_map[k] = '0;
        pm_held_den = 1;
        pm_zeros_seen = 0;
        pm_go(ST_DONE, RD_FIX, 1);
        pm_scale = 16'h0808;
        pm_loops = 0;
        pm_accum = 0;
        pm_active = 0;
    endfunction

    // Exp-Golomb / fixed bit reader; returns 1 when a value completes
    function automatic bit pm_bit(input bit b, output logic [31:0] v);
        logic [31:0] ue;
        if (pm_mode == RD_FIX) begin
            pm_gval = {pm_gval[30:0], b};
            pm_gzeros--;
            v = pm_gval;
            return pm_gzeros == 0;
        end
        if (!pm_phase) begin
            if (!b) begin
                pm_gzeros++;
                if (pm_gzeros < 32) return 0;
                ue = 32'hFFFF_FFFF;
            end else if (pm_gzeros == 0) begin
                ue = 0;
            end else begin
                pm_gval = 1;
                pm_phase = 1;
                return 0;
            end
        end else begin
            pm_gval = {pm_gval[30:0], b};
            pm_gzeros--;
            if (pm_gzeros != 0) return 0;
            ue = pm_gval - 1;
        end
        if (pm_mode == RD_SE) v = ue[0] ? (ue >> 1) + 1 : 32'd0 - (ue >> 1);
        else v = ue;
        return 1;
    endfunction

    function automatic void pm_next_list();
        int i;
        int lists;
        i = pm_loops[10:7] + 1;
        lists = (cu_chroma == 3) ? 12 : 8;
        if (i >= lists) begin
            pm_go(S_FRAMENUM, RD_UE, 0);
            return;
        end
        pm_loops = i << 7;
        pm_go(S_LISTFLAG, RD_FIX, 1);
    endfunction

    function automatic logic [15:0] sat16(input logic [63:0] x, input logic [63:0] sub);
        logic [63:0] r;
        r = (x > sub) ? x - sub : 0;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic void pm_close_sps();
        logic [63:0] fields, cx, cy;
        logic [31:0] cat;
        fields = 2 - cu_fmo;
        cat = cu_sepplane ? 0 : cu_chroma;
        cx = 2;
        cy = 2 * fields;
        if (cat == 0 || cat == 3) begin
            cx = 1;
            cy = fields;
        end else if (cat == 2) begin
            cy = fields;
        end
        cu_width  = {16'd0, sat16(({32'd0, cu_wmbs} + 1) * 16, cx * cu_crop_lr)};
        cu_height = {16'd0, sat16(({32'd0, cu_hmbs} + 1) * 16 * fields, cy * cu_crop_tb)};
        cu_aden = pm_held_den;
        pm_end(STAT_OK);
    endfunction

    // Syntax walk: act on one completed value
    function automatic void pm_value(input logic [31:0] v);
        int i, j, k;
        logic [7:0] last, nxt;
        case (pm_step)
            S_PROFILE: begin cu_profile = v; pm_go(S_CONSTR, RD_FIX, 8); end
            S_CONSTR:  pm_go(S_LEVEL, RD_FIX, 8);
            S_LEVEL:   begin pm_accum = v; pm_go(S_SPSID, RD_UE, 0); end
            S_SPSID: begin
                cu_pid = v;
                k = 0;
                while (k < 15 && lvl_id(k) < pm_accum) k++;
                if (k >= 15) pm_end(STAT_LEVEL);
                else if (v >= SEQ_SLOTS_DEF) pm_end(STAT_IDRANGE);
                else begin
                    cu_buffer = lvl_bytes(k);
                    pm_seq_buf[v] = cu_buffer;
                    if (cu_profile >= 100) pm_go(S_CHROMA, RD_UE, 0);
                    else pm_go(S_FRAMENUM, RD_UE, 0);
                end
            end
            S_CHROMA: begin
                cu_chroma = v;
                if (v == 3) pm_go(S_SEPPLANE, RD_FIX, 1);
                else pm_go(S_DEPTHL, RD_UE, 0);
            end
            S_SEPPLANE: begin cu_sepplane = v; pm_go(S_DEPTHL, RD_UE, 0); end
            S_DEPTHL: pm_go(S_DEPTHC, RD_UE, 0);
            S_DEPTHC: pm_go(S_BYPASS, RD_FIX, 1);
            S_BYPASS: pm_go(S_MATRIX, RD_FIX, 1);
            S_MATRIX: begin
                if (v != 0) begin
                    pm_loops = 0;
                    pm_go(S_LISTFLAG, RD_FIX, 1);
                end else pm_go(S_FRAMENUM, RD_UE, 0);
            end
            S_LISTFLAG: begin
                if (v != 0) begin
                    pm_scale = 16'h0808;
                    pm_loops = pm_loops & 16'h0780;
                    pm_go(S_DELTA, RD_SE, 0);
                end else pm_next_list();
            end
            S_DELTA: begin
                i = pm_loops[10:7];
                j = pm_loops[6:0] + 1;
                last = pm_scale[15:8];
                nxt = last + v[7:0];
                if (nxt != 0) last = nxt;
                pm_scale = {last, nxt};
                pm_loops = (i << 7) | (j & 127);
                if (nxt == 0 || j >= (i < 6 ? 16 : 64)) pm_next_list();
                else pm_go(S_DELTA, RD_SE, 0);
            end
            S_FRAMENUM: pm_go(S_POCTYPE, RD_UE, 0);
            S_POCTYPE: begin
                if (v == 0) pm_go(S_POCLSB, RD_UE, 0);
                else if (v == 1) pm_go(S_POCZERO, RD_FIX, 1);
                else if (v == 2) pm_go(S_REFS, RD_UE, 0);
                else pm_end(STAT_POC);
            end
            S_POCLSB: pm_go(S_REFS, RD_UE, 0);
            S_POCZERO: pm_go(S_OFFNR, RD_SE, 0);
            S_OFFNR: pm_go(S_OFFTB, RD_SE, 0);
            S_OFFTB: pm_go(S_CYCLE, RD_UE, 0);
            S_CYCLE: begin
                pm_accum = v;
                if (v == 0) pm_go(S_REFS, RD_UE, 0);
                else pm_go(S_OFFREF, RD_SE, 0);
            end
            S_OFFREF: begin
                pm_accum--;
                if (pm_accum == 0) pm_go(S_REFS, RD_UE, 0);
                else pm_go(S_OFFREF, RD_SE, 0);
            end
            S_REFS: pm_go(S_GAPS, RD_FIX, 1);
            S_GAPS: pm_go(S_WMBS, RD_UE, 0);
            S_WMBS: begin cu_wmbs = v; pm_go(S_HMBS, RD_UE, 0); end
            S_HMBS: begin cu_hmbs = v; pm_go(S_FMO, RD_FIX, 1); end
            S_FMO: begin
                cu_fmo = v;
                if (v != 0) pm_go(S_D8, RD_FIX, 1);
                else pm_go(S_MBAFF, RD_FIX, 1);
            end
            S_MBAFF: pm_go(S_D8, RD_FIX, 1);
            S_D8: pm_go(S_CROPF, RD_FIX, 1);
            S_CROPF: begin
                if (v != 0) pm_go(S_CL, RD_UE, 0);
                else pm_go(S_VUI, RD_FIX, 1);
            end
            S_CL: begin cu_crop_lr += v; pm_go(S_CR, RD_UE, 0); end
            S_CR: begin cu_crop_lr += v; pm_go(S_CT, RD_UE, 0); end
            S_CT: begin cu_crop_tb += v; pm_go(S_CB, RD_UE, 0); end
            S_CB: begin cu_crop_tb += v; pm_go(S_VUI, RD_FIX, 1); end
            S_VUI: begin
                if (v != 0) pm_go(S_ARP, RD_FIX, 1);
                else pm_close_sps();
            end
            S_ARP: begin
                if (v != 0) pm_go(S_ARIDC, RD_FIX, 8);
                else pm_close_sps();
            end
            S_ARIDC: begin
                if (v == 255) pm_go(S_SARW, RD_FIX, 16);
                else begin
                    if (v < 17) begin
                        cu_anum = aspect_n(v);
                        pm_held_den = aspect_d(v);
                    end
                    pm_close_sps();
                end
            end
            S_SARW: begin cu_anum = v; pm_go(S_SARH, RD_FIX, 16); end
            S_SARH: begin pm_held_den = v[15:0]; pm_close_sps(); end
            P_PPSID: begin cu_pid = v; pm_go(P_SPSID, RD_UE, 0); end
            P_SPSID: begin
                if (cu_pid >= PIC_SLOTS_DEF || v >= SEQ_SLOTS_DEF) pm_end(STAT_IDRANGE);
                else begin
                    pm_pic_map[cu_pid] = v[4:0];
                    pm_end(STAT_OK);
                end
            end
            L_FIRSTMB: pm_go(L_TYPE, RD_UE, 0);
            L_TYPE: begin
                if (v > 4) v -= 5;
                if (v == 0) cu_ftype = FT_P;
                else if (v == 1) cu_ftype = FT_B;
                else if (v == 2) cu_ftype = FT_I;
                if (v > 2) pm_end(STAT_SLICETYPE);
                else pm_go(L_PPSID, RD_UE, 0);
            end
            L_PPSID: begin
                cu_pid = v;
                if (v >= PIC_SLOTS_DEF) pm_end(STAT_IDRANGE);
                else begin
                    k = pm_pic_map[v];
                    if (pm_seq_buf[k] == 0) pm_end(STAT_NOBUF);
                    else begin
                        cu_buffer = pm_seq_buf[k];
                        pm_end(STAT_OK);
                    end
                end
            end
            default: pm_end(STAT_OK);
        endcase
    endfunction

    // Advance the predictor by one byte beat; queues a result on last_byte of an open unit
    function automatic void predict_byte(input logic [7:0] d, input bit fb, input bit lb);
        logic [31:0] v;
        t_result r;
        bit ok;
        if (fb) begin
            cu_status = 0; cu_kind = 0; cu_pid = 0; cu_width = 0; cu_height = 0;
            cu_anum = 0; cu_aden = 0; cu_buffer = 0; cu_ftype = 0; cu_profile = 0;
            cu_sepplane = 0; cu_fmo = 0; cu_wmbs = 0; cu_hmbs = 0;
            cu_crop_lr = 0; cu_crop_tb = 0;
            cu_chroma = 1;
            pm_active = 1;
            pm_zeros_seen = 0;
            pm_scale = 16'h0808;
            pm_loops = 0;
            pm_accum = 0;
            if (d[4:0] == NAL_SPS) begin cu_kind = KIND_SPS; pm_go(S_PROFILE, RD_FIX, 8); end
            else if (d[4:0] == NAL_PPS) begin cu_kind = KIND_PPS; pm_go(P_PPSID, RD_UE, 0); end
            else if (d[4:0] == NAL_SLICE || d[4:0] == NAL_IDR) begin
                cu_kind = KIND_SLICE;
                pm_go(L_FIRSTMB, RD_UE, 0);
            end else begin
                cu_kind = KIND_OTHER;
                pm_end(STAT_IGNORED);
            end
        end else begin
            if (!pm_active) return;
            if (pm_zeros_seen >= 2 && d == 8'h03) pm_zeros_seen = 0;
            else begin
                pm_zeros_seen = (d == 0) ? ((pm_zeros_seen < 2) ? pm_zeros_seen + 1 : 2) : 0;
                for (int b = 7; b >= 0 && pm_step != ST_DONE; b--)
                    if (pm_bit(d[b], v)) pm_value(v);
            end
        end
        if (!lb) return;
        if (pm_step != ST_DONE) pm_end(STAT_TRUNC);
        ok = (cu_status == STAT_OK);
        r.status = cu_status;
        r.kind   = cu_kind;
        r.pid    = cu_pid[7:0];
        r.width  = ok ? cu_width[15:0] : '0;
        r.height = ok ? cu_height[15:0] : '0;
        r.anum   = ok ? cu_anum[15:0] : '0;
        r.aden   = ok ? cu_aden[15:0] : '0;
        r.buffer = ok ? cu_buffer[24:0] : '0;
        r.ftype  = ok ? cu_ftype[1:0] : '0;
        expected_q.push_back(r);
        pm_active = 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // Send one byte beat and feed the predictor when it is taken
    task automatic send_byte(input logic [7:0] d, input bit fb, input bit lb);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= d;
        in_ch.first_byte <= fb;
        in_ch.last_byte  <= lb;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_byte(d, fb, lb);
    endtask

    // Pad, escape when asked, and send the bit string as a unit after a header byte
    task automatic send_unit(input logic [7:0] hdr, input bit escape);
        logic [7:0] bytes_q[$];
        logic [7:0] b;
        int zr;
        while (bits_q.size() % 8 != 0) bits_q.push_back(1'b0);
        zr = 0;
        while (bits_q.size() > 0) begin
            for (int k = 7; k >= 0; k--) b[k] = bits_q.pop_front();
            if (escape && zr >= 2 && b <= 8'h03) begin
                bytes_q.push_back(8'h03);
                zr = 0;
            end
            bytes_q.push_back(b);
            zr = (b == 0) ? zr + 1 : 0;
        end
        send_byte(hdr, 1'b1, bytes_q.size() == 0);
        foreach (bytes_q[k]) send_byte(bytes_q[k], 1'b0, k == bytes_q.size() - 1);
    endtask

    // Build a sequence set with random content
    function automatic void build_sps(input int id, input int level, input bit full);
        int prof, chroma, poc;
        prof = $urandom_range(1) ? 100 + $urandom_range(155) : $urandom_range(99);
        put_bits(prof, 8);
        put_bits($urandom, 8);
        put_bits(level, 8);
        put_ue(id);
        if (prof >= 100) begin
            chroma = $urandom_range(4);
            put_ue(chroma);
            if (chroma == 3) put_bits($urandom, 1);
            put_ue($urandom_range(6));
            put_ue($urandom_range(6));
            put_bits($urandom, 1);
            if (full && $urandom_range(2) == 0) begin
                put_bits(1, 1);
                for (int i = 0; i < (chroma == 3 ? 12 : 8); i++) begin
                    put_bits($urandom, 1);
                    if (bits_q[$]) begin
                        for (int j = 0; j < (i < 6 ? 16 : 64); j++)
                            put_se($urandom_range(1, 9));
                    end
                end
            end else put_bits(0, 1);
        end
        put_ue($urandom_range(12));
        poc = ($urandom_range(9) == 0) ? 3 + $urandom_range(5) : $urandom_range(2);
        put_ue(poc);
        if (poc == 0) put_ue($urandom_range(12));
        else if (poc == 1) begin
            put_bits($urandom, 1);
            put_se(int'($urandom_range(200)) - 100);
            put_se(int'($urandom_range(200)) - 100);
            put_ue($urandom_range(3));
            for (int k = 0; k < 4; k++) put_se(int'($urandom_range(20)) - 10);
        end
        put_ue($urandom_range(16));
        put_bits($urandom, 1);
        put_ue($urandom_range(1) ? $urandom_range(200) : $urandom_range(5000));
        put_ue($urandom_range(1) ? $urandom_range(100) : $urandom_range(5000));
        put_bits($urandom, 1);
        if (bits_q[$] == 0) put_bits($urandom, 1);
        put_bits($urandom, 1);
        put_bits($urandom, 1);
        if (bits_q[$]) for (int k = 0; k < 4; k++)
            put_ue($urandom_range(3) == 0 ? $urandom_range(3000) : $urandom_range(20));
        put_bits($urandom_range(3) != 0, 1);
        if (bits_q[$]) begin
            put_bits($urandom_range(3) != 0, 1);
            if (bits_q[$]) begin
                int idc;
                idc = $urandom_range(2) == 0 ? 255 : $urandom_range(254);
                put_bits(idc, 8);
                if (idc == 255) put_bits($urandom, 32);
            end
        end
        put_bits($urandom, $urandom_range(16));
    endfunction

    function automatic void build_pps(input int pid, input int sid);
        put_ue(pid);
        put_ue(sid);
        put_bits($urandom, $urandom_range(20));
    endfunction

    function automatic void build_slice(input int stype, input int pid);
        put_ue($urandom_range(500));
        put_ue(stype);
        put_ue(pid);
        put_bits($urandom, $urandom_range(20));
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result beat", 32'd1, 32'd0);
            end else begin
                w = expected_q.pop_front();
                if (out_ch.status !== w.status) report_mismatch("status", out_ch.status, w.status);
                if (out_ch.unit_kind !== w.kind) report_mismatch("kind", out_ch.unit_kind, w.kind);
                if (out_ch.param_id !== w.pid) report_mismatch("param_id", out_ch.param_id, w.pid);
                if (out_ch.pixel_width !== w.width)
                    report_mismatch("width", out_ch.pixel_width, w.width);
                if (out_ch.pixel_height !== w.height)
                    report_mismatch("height", out_ch.pixel_height, w.height);
                if (out_ch.aspect_num !== w.anum)
                    report_mismatch("aspect_num", out_ch.aspect_num, w.anum);
                if (out_ch.aspect_den !== w.aden)
                    report_mismatch("aspect_den", out_ch.aspect_den, w.aden);
                if (out_ch.buffer_bytes !== w.buffer)
                    report_mismatch("buffer", out_ch.buffer_bytes, w.buffer);
                if (out_ch.frame_type !== w.ftype)
                    report_mismatch("frame_type", out_ch.frame_type, w.ftype);
            end
        end
    end

    // Receiver ready, with random stalls and a long hold-off window
    always @(posedge i_clk) begin
        out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Directed: extremes, every kind, each special case
    task automatic test_directed();
        send_byte(8'h55, 1'b0, 1'b1);                  // stray byte before any header
        send_byte(8'h67, 1'b1, 1'b1);                  // header-only sequence set: truncated
        send_byte(8'hFF, 1'b1, 1'b1);                  // other type
        build_sps(0, 51, 1); send_unit(8'h67, 1);
        build_sps(31, 10, 0); send_unit(8'hE7, 1);
        build_sps(32, 40, 0); send_unit(8'h07, 1);     // id range
        build_sps(3, 52, 0); send_unit(8'h27, 1);      // level unknown
        build_pps(0, 0); send_unit(8'h68, 1);
        build_pps(255, 31); send_unit(8'h68, 1);
        build_pps(256, 0); send_unit(8'h68, 1);
        build_pps(5, 32); send_unit(8'h68, 1);
        build_slice(0, 0); send_unit(8'h65, 1);
        build_slice(6, 255); send_unit(8'h41, 1);
        build_slice(7, 255); send_unit(8'h41, 1);
        build_slice(3, 0); send_unit(8'h41, 1);        // bad slice type
        build_slice(10, 0); send_unit(8'h41, 1);
        build_slice(2, 300); send_unit(8'h41, 1);      // pps id range
        build_slice(2, 7); send_unit(8'h41, 1);        // unmapped pps id: falls back to sequence set 0
        // Long Golomb code: 39 zeros then a one
        put_bits(0, 32); put_bits(1, 8); send_unit(8'h41, 0);
        // New header inside a unit, then a byte after the end
        send_byte(8'h68, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        build_pps(1, 0); send_unit(8'h68, 1);
        send_byte(8'hAA, 1'b0, 1'b0);
        // Escapes in raw zero bytes
        send_byte(8'h41, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h03, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
    endtask

    // Random: mostly well-formed units with random content, some noise
    task automatic test_random(input int units);
        int sel;
        for (int n = 0; n < units; n++) begin
            sel = $urandom_range(99);
            if (sel < 30) begin
                build_sps($urandom_range(9) == 0 ? $urandom_range(33, 40) : $urandom_range(31),
                          $urandom_range(9) == 0 ? $urandom_range(52, 255) : lvl_id($urandom_range(14)),
                          $urandom_range(3) == 0);
                send_unit({3'($urandom_range(7)), NAL_SPS}, $urandom_range(9) != 0);
            end else if (sel < 55) begin
                build_pps($urandom_range(19) == 0 ? 256 : $urandom_range(255),
                          $urandom_range(19) == 0 ? 40 : $urandom_range(31));
                send_unit({3'($urandom_range(7)), NAL_PPS}, 1);
            end else if (sel < 85) begin
                build_slice($urandom_range(11), $urandom_range(19) == 0 ? 300 : $urandom_range(255));
                send_unit({3'($urandom_range(7)), $urandom_range(1) ? NAL_IDR : NAL_SLICE}, 1);
            end else if (sel < 95) begin
                // truncated unit: few random bytes
                send_byte(8'($urandom), 1'b1, 1'b0);
                repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0, 1'b0);
                send_byte(8'($urandom), 1'b0, 1'b1);
            end else begin
                send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
            end
        end
    endtask

    // Long receiver hold-off while units keep coming
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1;
                repeat (600) @(posedge i_clk);
                hold_off = 0;
            end
            test_random(8);
        join
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.first_byte = 1'b0;
        in_ch.last_byte = 1'b0;
        hold_off = 0;
        fail_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pm_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        send_idle_pct = 9;  recv_idle_pct = 56;
        test_random(15);
        test_backpressure();
        send_idle_pct = 56; recv_idle_pct = 9;
        test_random(15);
        send_idle_pct = 0;  recv_idle_pct = 0;
        test_random(15);
        drain();

        if (fail_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #60ms;
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

// ===== h264_parameter_set_parser.f =====
hw/rtl/h264ps_pkg.sv
hw/rtl/h264ps_if.sv
hw/rtl/h264ps_front.sv
hw/rtl/h264ps_fifo.sv
hw/rtl/h264ps_back.sv
hw/rtl/h264_parameter_set_parser.sv
test/tb.sv
